// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL, clocked on clk with rst_n low masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FLVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/flvs_pkg.sv
// ----------------------------------------------------------------------------
// flvs_pkg
// Shared types and constants for the FLV tag stream scanner
// ----------------------------------------------------------------------------
`default_nettype none

package flvs_pkg;

  localparam int unsigned BUFFER_BYTES = 1048576;
  localparam int unsigned OFF_W        = 21;
  localparam int unsigned POS_W        = 25;
  localparam int unsigned MAXDUR_W     = 31;
  localparam int unsigned CFG_DATA_W   = 31;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [7:0] TAG_VIDEO   = 8'd9;
  localparam logic [3:0] FRAME_KEY   = 4'd1;
  localparam int unsigned HEADER_LEN  = 11;
  localparam int unsigned TRAILER_LEN = 4;
  localparam int unsigned MIN_BUFFER  = 15;

  // header byte positions
  localparam logic [POS_W-1:0] POS_SIZE_END = 25'd3;
  localparam logic [POS_W-1:0] POS_TS_END   = 25'd6;
  localparam logic [POS_W-1:0] POS_TS_EXT   = 25'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR  = 1'b1;

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'b0001,
    PH_MEASURE = 4'b0010,
    PH_DONE    = 4'b0100,
    PH_FAILED  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_BAD_TRAILER = 3'd2,
    ST_NO_KEYFRAME = 3'd3,
    ST_TOO_SHORT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] start_offset;
    logic [OFF_W-1:0] valid_length;
    logic [31:0]      duration_ms;
    logic [OFF_W-1:0] video_tags;
    logic [31:0]      first_timestamp;
  } out_item_t;

  // scan state after the byte just taken, handed to the report logic
  typedef struct packed {
    logic             fire;
    phase_t           phase;
    status_t          status;
    logic             tag_open;
    logic [OFF_W-1:0] byte_count;
    logic [OFF_W-1:0] measure_start;
    logic [OFF_W-1:0] good_length;
    logic [31:0]      first_stamp;
    logic [31:0]      last_stamp;
    logic [OFF_W-1:0] video_count;
  } scan_snap_t;

endpackage

`default_nettype wire

// File: src/flvs_tag_parser.sv
// ----------------------------------------------------------------------------
// flvs_tag_parser
// Per-byte tag walker: header fields, payload skip, trailer check, measuring
// ----------------------------------------------------------------------------
`default_nettype none

module flvs_tag_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_acc,
  input  wire flvs_pkg::in_item_t               in_item,
  input  wire logic                             skip_to_keyframe,
  input  wire logic [flvs_pkg::MAXDUR_W-1:0]    max_duration_ms,
  output flvs_pkg::scan_snap_t                  snap
);
  import flvs_pkg::*;

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [OFF_W-1:0] tstart_r, tstart_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [23:0]      size_r, size_nxt;
  logic [31:0]      ts_r, ts_nxt;
  logic [31:0]      trl_r, trl_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [31:0]      first_r, first_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [OFF_W-1:0] vcnt_r, vcnt_nxt;
  logic [OFF_W-1:0] mstart_r, mstart_nxt;
  logic [OFF_W-1:0] glen_r, glen_nxt;
  phase_t           phase_r, phase_nxt;
  status_t          status_r, status_nxt;

  logic             take;
  logic             active;
  logic             finish;
  logic             good;
  logic             clear;
  phase_t           ph0;
  logic [POS_W-1:0] size_p11;
  logic [POS_W-1:0] size_end;
  logic [31:0]      ts_full;
  logic [31:0]      dur_now;
  logic [OFF_W-1:0] total;
  logic [7:0]       b;

  always_comb begin
    b        = in_item.data_byte;
    take     = off_r < OFF_W'(BUFFER_BYTES);
    ph0      = (off_r == '0) ? (skip_to_keyframe ? PH_SEARCH : PH_MEASURE) : phase_r;
    active   = take && (ph0 == PH_SEARCH || ph0 == PH_MEASURE);
    size_p11 = {1'b0, size_r} + POS_W'(HEADER_LEN);
    size_end = size_p11 + POS_W'(TRAILER_LEN - 1);
    ts_full  = {b, ts_r[23:0]};
    dur_now  = last_r - first_r;
    total    = size_r[OFF_W-1:0] + OFF_W'(HEADER_LEN + TRAILER_LEN);

    off_nxt    = off_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    kind_nxt   = kind_r;
    size_nxt   = size_r;
    ts_nxt     = ts_r;
    trl_nxt    = trl_r;
    nib_nxt    = nib_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    vcnt_nxt   = vcnt_r;
    mstart_nxt = mstart_r;
    glen_nxt   = glen_r;
    phase_nxt  = phase_r;
    status_nxt = status_r;
    finish     = 1'b0;
    good       = 1'b0;

    if (in_acc && take) begin
      off_nxt   = off_r + 1'b1;
      phase_nxt = ph0;
    end

    if (in_acc && active) begin
      if (pos_r == '0) begin
        tstart_nxt = off_r;
        kind_nxt   = b;
        size_nxt   = '0;
        ts_nxt     = '0;
        nib_nxt    = '0;
        trl_nxt    = '0;
        if (ph0 == PH_MEASURE && b == TAG_VIDEO) begin
          vcnt_nxt = vcnt_r + 1'b1;
        end
      end else if (pos_r <= POS_SIZE_END) begin
        size_nxt = {size_r[15:0], b};
      end else if (pos_r <= POS_TS_END) begin
        ts_nxt = {8'h00, ts_r[15:0], b};
      end else if (pos_r == POS_TS_EXT) begin
        ts_nxt = ts_full;
        if (ph0 == PH_MEASURE) begin
          last_nxt = ts_full;
          if (tstart_r == mstart_r) begin
            first_nxt = ts_full;
          end
        end
      end else if (pos_r >= POS_W'(HEADER_LEN)) begin
        if (pos_r < size_p11) begin
          // first payload byte carries the frame type in its upper nibble
          if (pos_r == POS_W'(HEADER_LEN)) begin
            nib_nxt = b[7:4];
          end
        end else begin
          trl_nxt = {trl_r[23:0], b};
        end
      end

      finish = (pos_r >= POS_W'(HEADER_LEN)) && (pos_r == size_end);
      good   = trl_nxt == {7'b0, size_p11};
      pos_nxt = finish ? '0 : pos_r + 1'b1;

      if (finish) begin
        if (ph0 == PH_SEARCH) begin
          if (kind_r == TAG_VIDEO && nib_r == FRAME_KEY) begin
            if (!good) begin
              status_nxt = ST_BAD_TRAILER;
              phase_nxt  = PH_FAILED;
            end else begin
              phase_nxt  = PH_MEASURE;
              mstart_nxt = tstart_r;
              first_nxt  = ts_r;
              last_nxt   = ts_r;
              vcnt_nxt   = OFF_W'(1);
              glen_nxt   = total;
            end
          end
        end else begin
          if (!good) begin
            status_nxt = ST_BAD_TRAILER;
            phase_nxt  = PH_DONE;
          end else begin
            glen_nxt = glen_r + total;
            if (max_duration_ms != '0 && dur_now >= {1'b0, max_duration_ms}) begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
    end

    snap.fire          = in_acc && in_item.last;
    snap.phase         = phase_nxt;
    snap.status        = status_nxt;
    snap.tag_open      = pos_nxt != '0;
    snap.byte_count    = off_nxt;
    snap.measure_start = mstart_nxt;
    snap.good_length   = glen_nxt;
    snap.first_stamp   = first_nxt;
    snap.last_stamp    = last_nxt;
    snap.video_count   = vcnt_nxt;
    clear              = snap.fire;
  end

  // a reported buffer starts the next one from scratch
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      off_r    <= '0;
      pos_r    <= '0;
      tstart_r <= '0;
      kind_r   <= '0;
      size_r   <= '0;
      ts_r     <= '0;
      trl_r    <= '0;
      nib_r    <= '0;
      first_r  <= '0;
      last_r   <= '0;
      vcnt_r   <= '0;
      mstart_r <= '0;
      glen_r   <= '0;
      phase_r  <= PH_MEASURE;
      status_r <= ST_OK;
    end else begin
      off_r    <= off_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      kind_r   <= kind_nxt;
      size_r   <= size_nxt;
      ts_r     <= ts_nxt;
      trl_r    <= trl_nxt;
      nib_r    <= nib_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      vcnt_r   <= vcnt_nxt;
      mstart_r <= mstart_nxt;
      glen_r   <= glen_nxt;
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/flvs_report.sv
// ----------------------------------------------------------------------------
// flvs_report
// Forms the end-of-buffer result from the scan state after the last byte
// ----------------------------------------------------------------------------
`default_nettype none

module flvs_report (
  input  wire flvs_pkg::scan_snap_t snap,
  output flvs_pkg::out_item_t       res
);
  import flvs_pkg::*;

  logic    measured;
  logic    too_short;
  status_t st;

  always_comb begin
    too_short = snap.byte_count < OFF_W'(MIN_BUFFER);
    measured  = (snap.phase == PH_MEASURE || snap.phase == PH_DONE) && !too_short;

    if (too_short) begin
      st = ST_TOO_SHORT;
    end else if (snap.phase == PH_FAILED || snap.phase == PH_DONE) begin
      st = snap.status;
    end else if (snap.tag_open) begin
      st = ST_TRUNCATED;
    end else if (snap.phase == PH_SEARCH) begin
      st = ST_NO_KEYFRAME;
    end else begin
      st = ST_OK;
    end

    res.status          = st;
    res.start_offset    = measured ? snap.measure_start : '0;
    res.valid_length    = measured ? snap.good_length : '0;
    res.duration_ms     = measured ? (snap.last_stamp - snap.first_stamp) : '0;
    res.video_tags      = measured ? snap.video_count : '0;
    res.first_timestamp = (measured && st == ST_OK) ? snap.first_stamp : '0;
  end

endmodule

`default_nettype wire

// File: src/flv_tag_stream_scanner.sv
// ----------------------------------------------------------------------------
// flv_tag_stream_scanner
// Byte-wise FLV tag scanner reporting measured span, duration and video tags
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte of the tag buffer per transaction, last marks the end of
//           the buffer. A byte is taken on any cycle with in_valid high and
//           in_stall low, so a buffer streams at one byte per cycle.
//   out_* : one result per buffer, registered (into skid if a result waits)
//           from the transaction with last; held until out_stall is low.
//   cfg_* : write-only registers (index 0 skip_to_keyframe, index 1 max_duration_ms);
//           the user must write them while the scanner is idle; the block does not check.
//   Each byte is decoded by the tag walker in the cycle it is taken, and the
//   report is formed from its updated state straight into the output stage.
//   Throughput is 1 byte per cycle while in_stall is low. A two-entry output
//   stage (result register plus skid) lets bytes keep flowing while a result
//   waits; in_stall rises only when both entries hold results, i.e. two
//   buffers have ended under a stalled output.
//   Reset (rst_n low, synchronous) clears both registers to 0, empties the
//   output stage and starts a fresh buffer at offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flv_tag_stream_scanner (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire flvs_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output flvs_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [flvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [flvs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import flvs_pkg::*;

  logic                skip_r;
  logic [MAXDUR_W-1:0] max_dur_r;

  logic       in_acc;
  logic       push;
  logic       take;
  scan_snap_t snap;
  out_item_t  res;

  out_item_t  out_data_r, out_data_nxt;
  out_item_t  skid_r, skid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r    <= 1'b0;
      max_dur_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP_KEY: skip_r    <= cfg_data[0];
        CFG_MAX_DUR:  max_dur_r <= cfg_data[MAXDUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid && !in_stall;

  flvs_tag_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_acc           (in_acc),
    .in_item          (in_data),
    .skip_to_keyframe (skip_r),
    .max_duration_ms  (max_dur_r),
    .snap             (snap)
  );

  flvs_report u_report (
    .snap (snap),
    .res  (res)
  );

  // result register with a skid entry behind it
  always_comb begin
    push           = snap.fire;
    take           = out_valid_r && !out_stall;
    out_data_nxt   = out_data_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;

    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FLVS_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds data with empty output")
  `FLVS_ASSERT_NEXT(a_push_to_skid, push && out_valid_r && out_stall && !skid_valid_r, skid_valid_r, "result lost under stall")
  `FLVS_ASSERT_IMP(a_short_clear, out_valid_r && out_data_r.status == ST_TOO_SHORT, out_data_r.start_offset == '0 && out_data_r.valid_length == '0 && out_data_r.video_tags == '0, "short buffer with measured fields")
  `FLVS_ASSERT_IMP(a_first_ts_ok, out_valid_r && out_data_r.status != ST_OK, out_data_r.first_timestamp == '0, "first timestamp on failed buffer")

endmodule

`default_nettype wire
